@@ sv/yb2b_pkg.sv @@
// Shared types, coefficients and register indexes of the YUV420SP to BGR block converter.
package yb2b_pkg;

    // Input item: one 2x2 luma block and its shared chroma pair.
    typedef struct packed {
        logic [7:0] luma_top_left;
        logic [7:0] luma_top_right;
        logic [7:0] luma_bottom_left;
        logic [7:0] luma_bottom_right;
        logic [7:0] chroma_first;
        logic [7:0] chroma_second;
        logic       last_block;
    } t_in_item;

    // Result item: one row pair of BGRA pixels.
    typedef struct packed {
        logic       bottom_row;
        logic       block_end;
        logic [7:0] blue_left;
        logic [7:0] green_left;
        logic [7:0] red_left;
        logic [7:0] alpha_left;
        logic [7:0] blue_right;
        logic [7:0] green_right;
        logic [7:0] red_right;
        logic [7:0] alpha_right;
    } t_out_item;

    // One converted pixel as produced by a lane.
    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_pix;

    // Control that travels beside the datapath stages.
    typedef struct packed {
        logic valid;
        logic last;
    } t_ctl;

    // Signed width that holds every intermediate channel sum.
    localparam int TERM_W = 17;
    typedef logic signed [TERM_W-1:0] t_term;

    // Number of luma lanes (one per pixel of the 2x2 block).
    localparam int NUM_LANES = 4;

    // Fixed-point constants (6 fractional bits).
    localparam logic [7:0] CHROMA_CLAMP = 8'd240;
    localparam logic signed [8:0] CHROMA_BIAS = 9'sd128;
    localparam t_term COEF_RV = 17'sd102;
    localparam t_term COEF_GV = -17'sd52;
    localparam t_term COEF_GU = -17'sd25;
    localparam t_term COEF_BU = 17'sd129;
    localparam t_term COEF_Y = 17'sd74;
    localparam t_term Y_OFFSET = 17'sd1135;
    localparam int FRAC_BITS = 6;
    localparam logic [7:0] ALPHA_OPAQUE = 8'd255;
    localparam logic [7:0] ALPHA_NONE = 8'd0;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_CHROMA_U_FIRST = 2'd0;
    localparam t_cfg_idx CFG_FOUR_CHANNEL = 2'd1;

endpackage

@@ sv/yb2b_chroma.sv @@
// Chroma front stage: clamps and centers the chroma pair and forms the chroma terms.
module yb2b_chroma import yb2b_pkg::*; (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  logic                        i_u_first,
    input  t_in_item                    i_item,
    output t_ctl                        o_ctl,
    output t_term                       o_ruv,
    output t_term                       o_guv,
    output t_term                       o_buv,
    output logic [NUM_LANES-1:0][7:0]   o_luma
);

    // Clamp above at the chroma limit, then remove the bias.
    function automatic logic signed [8:0] center(input logic [7:0] raw);
        logic [7:0] clamped;
        clamped = (raw > CHROMA_CLAMP) ? CHROMA_CLAMP : raw;
        return $signed({1'b0, clamped}) - CHROMA_BIAS;
    endfunction

    logic signed [8:0] c0;
    logic signed [8:0] c1;
    logic signed [8:0] u;
    logic signed [8:0] v;
    t_ctl  r_ctl;
    t_term r_ruv;
    t_term r_guv;
    t_term r_buv;
    logic [NUM_LANES-1:0][7:0] r_luma;

    // Pick U and V according to the chroma order.
    always_comb begin
        c0 = center(i_item.chroma_first);
        c1 = center(i_item.chroma_second);
        u  = i_u_first ? c0 : c1;
        v  = i_u_first ? c1 : c0;
    end

    // Control register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl.valid <= i_accept;
            r_ctl.last  <= i_item.last_block;
        end
    end

    // Chroma terms and luma bytes, loaded with each accepted item.
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_ruv <= t_term'(v) * COEF_RV;
            r_guv <= t_term'(v) * COEF_GV + t_term'(u) * COEF_GU;
            r_buv <= t_term'(u) * COEF_BU;
            r_luma[0] <= i_item.luma_top_left;
            r_luma[1] <= i_item.luma_top_right;
            r_luma[2] <= i_item.luma_bottom_left;
            r_luma[3] <= i_item.luma_bottom_right;
        end
    end

    assign o_ctl  = r_ctl;
    assign o_ruv  = r_ruv;
    assign o_guv  = r_guv;
    assign o_buv  = r_buv;
    assign o_luma = r_luma;

endmodule

@@ sv/yb2b_lane.sv @@
// One pixel lane: luma scaling, chroma term addition, shift and saturation.
module yb2b_lane import yb2b_pkg::*; (
    input  logic       i_clk,
    input  logic [7:0] i_luma,
    input  t_term      i_ruv,
    input  t_term      i_guv,
    input  t_term      i_buv,
    output t_pix       o_pix
);

    // Floor shift by the fraction bits and clamp to a byte.
    function automatic logic [7:0] to_byte(input t_term sum);
        logic [TERM_W-FRAC_BITS-1:0] q;
        q = sum[TERM_W-1:FRAC_BITS];
        if (sum < 0) begin
            return 8'd0;
        end else if (q > (TERM_W-FRAC_BITS)'(255)) begin
            return 8'd255;
        end else begin
            return q[7:0];
        end
    endfunction

    t_term y;
    t_pix  r_pix;

    // Scaled luma base term.
    assign y = t_term'({{(TERM_W-8){1'b0}}, i_luma}) * COEF_Y - Y_OFFSET;

    // Registered channel outputs.
    always_ff @(posedge i_clk) begin
        r_pix.blue  <= to_byte(y + i_buv);
        r_pix.green <= to_byte(y + i_guv);
        r_pix.red   <= to_byte(y + i_ruv);
    end

    assign o_pix = r_pix;

endmodule

@@ sv/yb2b_merge.sv @@
// Output merge: gathers the four lanes into a top row item and then a bottom row item.
module yb2b_merge import yb2b_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_ctl                    i_ctl,
    input  logic                    i_four_channel,
    input  t_pix [NUM_LANES-1:0]    i_pix,
    output logic                    o_res_valid,
    output t_out_item               o_res
);

    logic [7:0] alpha;
    t_out_item  top_item;
    t_out_item  bot_item;
    logic       r_valid;
    logic       r_pend;
    t_out_item  r_out;
    t_out_item  r_bot;

    assign alpha = i_four_channel ? ALPHA_OPAQUE : ALPHA_NONE;

    // Assemble both row pairs from the lane results.
    always_comb begin
        top_item.bottom_row  = 1'b0;
        top_item.block_end   = i_ctl.last;
        top_item.blue_left   = i_pix[0].blue;
        top_item.green_left  = i_pix[0].green;
        top_item.red_left    = i_pix[0].red;
        top_item.alpha_left  = alpha;
        top_item.blue_right  = i_pix[1].blue;
        top_item.green_right = i_pix[1].green;
        top_item.red_right   = i_pix[1].red;
        top_item.alpha_right = alpha;
        bot_item             = top_item;
        bot_item.bottom_row  = 1'b1;
        bot_item.blue_left   = i_pix[2].blue;
        bot_item.green_left  = i_pix[2].green;
        bot_item.red_left    = i_pix[2].red;
        bot_item.blue_right  = i_pix[3].blue;
        bot_item.green_right = i_pix[3].green;
        bot_item.red_right   = i_pix[3].red;
    end

    // Control: the top row item is registered straight out, the bottom row item follows in the next cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_valid <= i_ctl.valid || r_pend;
            r_pend  <= i_ctl.valid;
        end
    end

    // Output and held bottom row payload.
    always_ff @(posedge i_clk) begin
        if (i_ctl.valid) begin
            r_out <= top_item;
            r_bot <= bot_item;
        end else if (r_pend) begin
            r_out <= r_bot;
        end
    end

    assign o_res_valid = r_valid;
    assign o_res       = r_out;

endmodule

@@ sv/yuv420sp_to_bgr_block_top.sv @@
// Top level of the YUV420SP 2x2 block to BGR/BGRA converter.
// The top row item passes the chroma stage, lane and merge output registers,
// the bottom row item comes in the cycle after it.
// A new block is accepted only while busy is low, since the single output port carries
// two row items per block; busy is high in the cycle after each accept.
// Reset (synchronous, active low) clears all valid flags and restores the registers
// to NV12 order and three-channel mode. Results cannot be stalled by the receiver.
module yuv420sp_to_bgr_block_top import yb2b_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  t_in_item   i_item,
    output logic       o_res_valid,
    output t_out_item  o_res,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  t_cfg_idx   i_cfg_index,
    input  logic       i_cfg_data
);

    logic  accept;
    logic  r_busy;
    logic  r_chroma_u_first;
    logic  r_four_channel;
    t_ctl  chroma_ctl;
    t_ctl  r_lane_ctl;
    t_term ruv;
    t_term guv;
    t_term buv;
    logic [NUM_LANES-1:0][7:0] luma;
    t_pix [NUM_LANES-1:0]      pix;

    assign accept      = start && !r_busy;
    assign busy        = r_busy;
    assign o_cfg_ready = 1'b1;

    // Busy is raised in the cycle after each accepted item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= accept;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chroma_u_first <= 1'b1;
            r_four_channel   <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_CHROMA_U_FIRST: r_chroma_u_first <= i_cfg_data;
                CFG_FOUR_CHANNEL:   r_four_channel   <= i_cfg_data;
                default:            ;
            endcase
        end
    end

    // Chroma preparation stage.
    yb2b_chroma u_chroma (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_u_first (r_chroma_u_first),
        .i_item    (i_item),
        .o_ctl     (chroma_ctl),
        .o_ruv     (ruv),
        .o_guv     (guv),
        .o_buv     (buv),
        .o_luma    (luma)
    );

    // Four pixel lanes working side by side.
    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        yb2b_lane u_lane (
            .i_clk  (i_clk),
            .i_luma (luma[g]),
            .i_ruv  (ruv),
            .i_guv  (guv),
            .i_buv  (buv),
            .o_pix  (pix[g])
        );
    end

    // Control that follows the lane stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lane_ctl <= '0;
        end else begin
            r_lane_ctl <= chroma_ctl;
        end
    end

    // Row pair merge and output register.
    yb2b_merge u_merge (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (r_lane_ctl),
        .i_four_channel (r_four_channel),
        .i_pix          (pix),
        .o_res_valid    (o_res_valid),
        .o_res          (o_res)
    );

`ifndef SYNTHESIS
    // An accepted item blocks the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("busy not raised after an accepted item");

    // Each accepted item produces its top row item after the chroma, lane and merge registers.
    a_top_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##3 (o_res_valid && !o_res.bottom_row))
        else $error("top row item missing after accept");

    // A top row item is always followed by its bottom row item.
    a_bottom_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !o_res.bottom_row) |=> (o_res_valid && o_res.bottom_row))
        else $error("bottom row item did not follow top row item");

    // A bottom row item only ever follows a top row item of the same block.
    a_bottom_pairs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.bottom_row) |->
            ($past(o_res_valid) && !$past(o_res.bottom_row)
             && ($past(o_res.block_end) == o_res.block_end)))
        else $error("bottom row item without matching top row item");
`endif

endmodule

@@ bench/yuv420sp_to_bgr_block_top_tb.sv @@
// Self-checking testbench for the YUV420SP 2x2 block to BGR/BGRA converter.
module yuv420sp_to_bgr_block_top_tb import yb2b_pkg::*; ();

    // Fixed-point conversion constants, kept apart from the design's own copies.
    localparam int Y_GAIN     = 74;
    localparam int Y_BIAS     = 1135;
    localparam int CHROMA_MAX = 240;
    localparam int CHROMA_MID = 128;
    localparam int RV_GAIN    = 102;
    localparam int GV_GAIN    = -52;
    localparam int GU_GAIN    = -25;
    localparam int BU_GAIN    = 129;
    localparam int FRAC       = 6;

    // Register indexes past the end of the map; writes to them must be dropped.
    localparam t_cfg_idx CFG_SPARE_LO = 2'd2;
    localparam t_cfg_idx CFG_SPARE_HI = 2'd3;

    localparam int WATCHDOG_LIMIT = 200;
    localparam int RANDOM_PER_PHASE = 80;
    localparam int NUM_PHASES = 5;

    // One row of the directed table; gray holds the expected level per pixel
    // (top left, top right, bottom left, bottom right) when known is set.
    typedef struct packed {
        t_in_item    blk;
        logic        known;
        logic [31:0] gray;
    } t_row;

    logic       i_clk;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    t_in_item   i_item;
    logic       o_res_valid;
    t_out_item  o_res;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    t_cfg_idx   i_cfg_index;
    logic       i_cfg_data;

    // Mirror of the configuration registers.
    logic nv12_order;
    logic four_ch;

    bit        gaps_on;
    t_row      stim_table[$];
    t_out_item pending_rows[$];
    int        fails;
    int        blocks_sent;
    int        rows_checked;
    int        quiet_cycles;

    yuv420sp_to_bgr_block_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_res_valid (o_res_valid),
        .o_res       (o_res),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Chroma byte clamped at the top of the video range, then centered on zero.
    function automatic int centered(logic [7:0] c);
        int val;
        val = int'(c);
        if (val > CHROMA_MAX) val = CHROMA_MAX;
        return val - CHROMA_MID;
    endfunction

    // Drop the fraction bits and saturate to a byte.
    function automatic logic [7:0] clip(int sum);
        int q;
        if (sum < 0) return 8'd0;
        q = sum >>> FRAC;
        if (q > 255) return 8'd255;
        return 8'(q);
    endfunction

    // One pixel as {blue, green, red}.
    function automatic logic [23:0] shade(logic [7:0] luma, int rv, int gv, int bu);
        int base;
        base = int'(luma) * Y_GAIN - Y_BIAS;
        return {clip(base + bu), clip(base + gv), clip(base + rv)};
    endfunction

    function automatic logic [7:0] alpha_byte();
        return four_ch ? 8'd255 : 8'd0;
    endfunction

    // Predict both row-pair items of a block under the current register settings.
    function automatic void convert_block(input t_in_item blk, output t_out_item top,
                                          output t_out_item bot);
        int c0, c1, u, v, rv, gv, bu;
        c0 = centered(blk.chroma_first);
        c1 = centered(blk.chroma_second);
        u  = nv12_order ? c0 : c1;
        v  = nv12_order ? c1 : c0;
        rv = RV_GAIN * v;
        gv = GV_GAIN * v + GU_GAIN * u;
        bu = BU_GAIN * u;
        top.bottom_row = 1'b0;
        top.block_end  = blk.last_block;
        {top.blue_left, top.green_left, top.red_left} = shade(blk.luma_top_left, rv, gv, bu);
        {top.blue_right, top.green_right, top.red_right} =
            shade(blk.luma_top_right, rv, gv, bu);
        top.alpha_left  = alpha_byte();
        top.alpha_right = alpha_byte();
        bot = top;
        bot.bottom_row = 1'b1;
        {bot.blue_left, bot.green_left, bot.red_left} =
            shade(blk.luma_bottom_left, rv, gv, bu);
        {bot.blue_right, bot.green_right, bot.red_right} =
            shade(blk.luma_bottom_right, rv, gv, bu);
    endfunction

    // Expected item for a neutral-chroma row, where each pixel is a plain gray level.
    function automatic t_out_item gray_row(logic bottom, logic lst, logic [7:0] left,
                                           logic [7:0] right);
        t_out_item res;
        res.bottom_row  = bottom;
        res.block_end   = lst;
        res.blue_left   = left;
        res.green_left  = left;
        res.red_left    = left;
        res.alpha_left  = alpha_byte();
        res.blue_right  = right;
        res.green_right = right;
        res.red_right   = right;
        res.alpha_right = alpha_byte();
        return res;
    endfunction

    function automatic void add_row(logic [7:0] tl, logic [7:0] tr, logic [7:0] bl,
                                    logic [7:0] br, logic [7:0] cf, logic [7:0] cs,
                                    logic lst, logic known, logic [31:0] gray);
        t_row r;
        r.blk.luma_top_left     = tl;
        r.blk.luma_top_right    = tr;
        r.blk.luma_bottom_left  = bl;
        r.blk.luma_bottom_right = br;
        r.blk.chroma_first      = cf;
        r.blk.chroma_second     = cs;
        r.blk.last_block        = lst;
        r.known = known;
        r.gray  = gray;
        stim_table.push_back(r);
    endfunction

    // Bytes lean toward the ends of the range and the chroma clamp point.
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(7))
            0: return 8'd0;
            1: return 8'd255;
            2: return 8'($urandom_range(255, 232));
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic t_in_item random_block();
        t_in_item b;
        b.luma_top_left     = pick_byte();
        b.luma_top_right    = pick_byte();
        b.luma_bottom_left  = pick_byte();
        b.luma_bottom_right = pick_byte();
        b.chroma_first      = pick_byte();
        b.chroma_second     = pick_byte();
        b.last_block        = 1'($urandom_range(1));
        return b;
    endfunction

    function automatic void check_byte(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endfunction

    // Present one block, with an occasional random gap in front, and wait for the
    // accepting edge. Called at a falling edge and returns at one.
    task automatic drive_block(input t_in_item blk, input t_out_item top,
                               input t_out_item bot);
        int gap;
        gap = 0;
        while (gaps_on && $urandom_range(99) < 12) gap++;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start  <= 1'b1;
        i_item <= blk;
        do @(posedge i_clk); while (busy !== 1'b0);
        pending_rows.push_back(top);
        pending_rows.push_back(bot);
        blocks_sent++;
        @(negedge i_clk);
    endtask

    // Hold until every expected row-pair item has come back.
    task automatic settle();
        while (pending_rows.size() != 0) @(negedge i_clk);
    endtask

    // Write both registers, with ignored writes to the unused indexes before and between them.
    task automatic program_regs(input logic nv12, input logic four);
        t_cfg_idx idx[4];
        logic     val[4];
        idx = '{CFG_SPARE_LO, CFG_CHROMA_U_FIRST, CFG_SPARE_HI, CFG_FOUR_CHANNEL};
        val = '{1'($urandom_range(1)), nv12, 1'($urandom_range(1)), four};
        for (int k = 0; k < 4; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data  <= val[k];
            do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
            case (idx[k])
                CFG_CHROMA_U_FIRST: nv12_order = val[k];
                CFG_FOUR_CHANNEL:   four_ch = val[k];
                default: ;
            endcase
            @(negedge i_clk);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Result checker and watchdog.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n) begin
            if (o_res_valid) begin
                rows_checked++;
                if (pending_rows.size() == 0) begin
                    $error("row-pair item arrived with nothing expected");
                    fails++;
                end else begin
                    want = pending_rows.pop_front();
                    check_byte("bottom_row", 8'(want.bottom_row), 8'(o_res.bottom_row));
                    check_byte("block_end", 8'(want.block_end), 8'(o_res.block_end));
                    check_byte("blue_left", want.blue_left, o_res.blue_left);
                    check_byte("green_left", want.green_left, o_res.green_left);
                    check_byte("red_left", want.red_left, o_res.red_left);
                    check_byte("alpha_left", want.alpha_left, o_res.alpha_left);
                    check_byte("blue_right", want.blue_right, o_res.blue_right);
                    check_byte("green_right", want.green_right, o_res.green_right);
                    check_byte("red_right", want.red_right, o_res.red_right);
                    check_byte("alpha_right", want.alpha_right, o_res.alpha_right);
                end
            end
            if ((start && !busy) || o_res_valid || (i_cfg_valid && o_cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
                $display("yuv420sp_to_bgr_block_top verification failed");
                $finish;
            end
        end
    end

    // Stimulus: five phases, each with a register setting, the directed table and then random
    // blocks; the first phase uses the setting left by reset, and the last repeats it.
    initial begin
        t_out_item top, bot;
        t_in_item  blk;
        start        = 1'b0;
        i_item       = '0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = CFG_CHROMA_U_FIRST;
        i_cfg_data   = 1'b0;
        i_rst_n      = 1'b0;
        nv12_order   = 1'b1;
        four_ch      = 1'b0;
        gaps_on      = 1'b1;
        fails        = 0;
        blocks_sent  = 0;
        rows_checked = 0;
        quiet_cycles = 0;

        // Neutral chroma gives gray pixels: black and saturated white.
        add_row(8'd0, 8'd0, 8'd0, 8'd0, 8'd128, 8'd128, 1'b0, 1'b1, 32'h00000000);
        add_row(8'd255, 8'd255, 8'd255, 8'd255, 8'd128, 8'd128, 1'b1, 1'b1, 32'hFFFFFFFF);
        add_row(8'd0, 8'd255, 8'd255, 8'd0, 8'd128, 8'd128, 1'b0, 1'b1, 32'h00FFFF00);
        add_row(8'd255, 8'd0, 8'd0, 8'd255, 8'd128, 8'd128, 1'b1, 1'b1, 32'hFF0000FF);
        // Chroma extremes and the clamp at 240.
        add_row(8'd128, 8'd128, 8'd128, 8'd128, 8'd0, 8'd0, 1'b0, 1'b0, '0);
        add_row(8'd128, 8'd128, 8'd128, 8'd128, 8'd255, 8'd255, 1'b1, 1'b0, '0);
        add_row(8'd128, 8'd128, 8'd128, 8'd128, 8'd240, 8'd240, 1'b0, 1'b0, '0);
        add_row(8'd128, 8'd128, 8'd128, 8'd128, 8'd241, 8'd241, 1'b1, 1'b0, '0);
        add_row(8'd128, 8'd128, 8'd128, 8'd128, 8'd239, 8'd241, 1'b0, 1'b0, '0);
        // Opposite chroma pairs expose the NV12/NV21 order.
        add_row(8'd200, 8'd60, 8'd16, 8'd235, 8'd0, 8'd255, 1'b0, 1'b0, '0);
        add_row(8'd200, 8'd60, 8'd16, 8'd235, 8'd255, 8'd0, 1'b1, 1'b0, '0);
        add_row(8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 1'b0, 1'b0, '0);
        add_row(8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 1'b1, 1'b0, '0);
        add_row(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 1'b0, 1'b0, '0);
        add_row(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 1'b0, 1'b0, '0);
        add_row(8'd16, 8'd235, 8'd16, 8'd235, 8'd128, 8'd0, 1'b1, 1'b0, '0);
        add_row(8'd16, 8'd235, 8'd16, 8'd235, 8'd0, 8'd128, 1'b0, 1'b0, '0);
        add_row(8'd128, 8'd128, 8'd128, 8'd128, 8'd128, 8'd255, 1'b1, 1'b0, '0);
        add_row(8'd128, 8'd128, 8'd128, 8'd128, 8'd255, 8'd128, 1'b0, 1'b0, '0);
        // Alternating bit patterns.
        add_row(8'hAA, 8'h55, 8'h55, 8'hAA, 8'hAA, 8'h55, 1'b1, 1'b0, '0);
        add_row(8'h55, 8'hAA, 8'hAA, 8'h55, 8'h55, 8'hAA, 1'b0, 1'b0, '0);
        add_row(8'd1, 8'd254, 8'd127, 8'd129, 8'd1, 8'd254, 1'b1, 1'b0, '0);

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            if (phase > 0) begin
                start <= 1'b0;
                @(negedge i_clk);
                settle();
                program_regs(phase % 2 == 0, phase <= 2);
            end
            // One setting runs back to back with no random gaps.
            gaps_on = (phase != 2);

            foreach (stim_table[i]) begin
                blk = stim_table[i].blk;
                if (stim_table[i].known) begin
                    top = gray_row(1'b0, blk.last_block, stim_table[i].gray[31:24],
                                   stim_table[i].gray[23:16]);
                    bot = gray_row(1'b1, blk.last_block, stim_table[i].gray[15:8],
                                   stim_table[i].gray[7:0]);
                end else begin
                    convert_block(blk, top, bot);
                end
                drive_block(blk, top, bot);
            end

            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                // Midway, let the pipeline run completely dry once.
                if (n == RANDOM_PER_PHASE / 2) begin
                    start <= 1'b0;
                    @(negedge i_clk);
                    settle();
                end
                blk = random_block();
                convert_block(blk, top, bot);
                drive_block(blk, top, bot);
            end
        end

        start <= 1'b0;
        @(negedge i_clk);
        settle();
        // Watch for stray items after the last expected one.
        repeat (8) @(negedge i_clk);

        $display("Sent %0d 2x2 blocks, checked %0d row-pair items in NV12 and NV21 order,",
                 blocks_sent, rows_checked);
        $display("three- and four-channel output, with ignored register writes; %0d errors.",
                 fails);
        if (fails == 0 && pending_rows.size() == 0) begin
            $display("yuv420sp_to_bgr_block_top verification clean");
        end else begin
            $display("yuv420sp_to_bgr_block_top verification failed");
        end
        $finish;
    end

endmodule
